// ===== design/krt_pkg.sv =====
`default_nettype none

package krt_pkg;

  localparam int KEY_W   = 16;
  localparam int PRICE_W = 24;
  localparam int QTY_W   = 16;
  localparam int REC_W   = KEY_W + PRICE_W + QTY_W;
  localparam int CNT_W   = 5;

  // Record layout: key on top, then price, then quantity
  localparam int QTY_LSB   = 0;
  localparam int PRICE_LSB = QTY_W;
  localparam int KEY_LSB   = QTY_W + PRICE_W;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FIND   = 2'd1,
    OP_UPDATE = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic       load;
    logic       add;
    logic       scan;
    logic       shift;
    logic       finish;
    logic       set_status;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic hit;
    logic scan_end;
    logic shift_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/keyed_record_table.sv =====
`default_nettype none

// Channel  Handshake         Payload
// in_      in_valid/stall    operation, item_key, item_price, item_quantity
// out_     out_valid/stall   status, found_key, found_price, found_quantity,
//                            entry_count
//
// Add appends the record with no search. Find, update and remove scan the
// used entries, and remove then copies later entries down: the single read
// port of the record RAM allows one entry compared or moved a cycle.
// One item is in work at a time; a new one is taken while a result waits.
// rst_n clears the entry count and control; record contents are not cleared.
// A stalled result holds the output register and delays the next result.

module keyed_record_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_operation,
  input  wire logic [15:0] in_item_key,
  input  wire logic [23:0] in_item_price,
  input  wire logic [15:0] in_item_quantity,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [15:0]      out_found_key,
  output logic [23:0]      out_found_price,
  output logic [15:0]      out_found_quantity,
  output logic [4:0]       out_entry_count
);

  import krt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  krt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  krt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_operation       (in_operation),
    .in_item_key        (in_item_key),
    .in_item_price      (in_item_price),
    .in_item_quantity   (in_item_quantity),
    .cmd                (cmd),
    .sts                (sts),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_key      (out_found_key),
    .out_found_price    (out_found_price),
    .out_found_quantity (out_found_quantity),
    .out_entry_count    (out_entry_count)
  );

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_entry_count == 5'(TABLE_DEPTH))
    else $error("full result with entry count below depth");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_found_key == '0) && (out_found_price == '0) && (out_found_quantity == '0))
    else $error("failed operation returned record fields");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !cmd.scan && !cmd.shift && !cmd.add)
    else $error("table access while idle");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.add, cmd.scan, cmd.shift, cmd.finish}))
    else $error("conflicting controller commands");

endmodule

`default_nettype wire

// ===== design/krt_ram.sv =====
`default_nettype none

module krt_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== design/krt_ctrl.sv =====
`default_nettype none

module krt_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [1:0]  in_operation,
  output logic             in_stall,
  input  wire krt_pkg::sts_t sts,
  output krt_pkg::cmd_t    cmd
);

  import krt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ADD    = 5'b00010,
    S_SCAN   = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (op_t'(in_operation) == OP_ADD) ? S_ADD : S_SCAN;
        end
      end
      S_ADD: begin
        if (sts.full) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FULL;
        end else begin
          cmd.add = 1'b1;
        end
        state_nxt = S_FINISH;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_nxt = (sts.op == OP_REMOVE) ? S_SHIFT : S_FINISH;
        end else if (sts.scan_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_MISSING;
          state_nxt      = S_FINISH;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ===== design/krt_dp.sv =====
`default_nettype none

module krt_dp #(
  parameter int TABLE_DEPTH = 16,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int IW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [1:0]           in_operation,
  input  wire logic [15:0]          in_item_key,
  input  wire logic [23:0]          in_item_price,
  input  wire logic [15:0]          in_item_quantity,
  input  wire krt_pkg::cmd_t        cmd,
  output krt_pkg::sts_t             sts,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [15:0]               out_found_key,
  output logic [23:0]               out_found_price,
  output logic [15:0]               out_found_quantity,
  output logic [4:0]                out_entry_count
);

  import krt_pkg::*;

  // Item registers
  op_t                op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [PRICE_W-1:0] price_r, price_nxt;
  logic [QTY_W-1:0]   qty_r, qty_nxt;

  // Table control
  logic [IW-1:0] count_r, count_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] chk_r, chk_nxt;
  logic          chk_v_r, chk_v_nxt;

  // Pending result
  logic [1:0]         res_status_r, res_status_nxt;
  logic [KEY_W-1:0]   res_key_r, res_key_nxt;
  logic [PRICE_W-1:0] res_price_r, res_price_nxt;
  logic [QTY_W-1:0]   res_qty_r, res_qty_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [KEY_W-1:0]   out_key_r, out_key_nxt;
  logic [PRICE_W-1:0] out_price_r, out_price_nxt;
  logic [QTY_W-1:0]   out_qty_r, out_qty_nxt;
  logic [CNT_W-1:0]   out_cnt_r, out_cnt_nxt;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [REC_W-1:0]   wdata;
  logic [AW-1:0]      raddr;
  logic [REC_W-1:0]   rd_data;
  logic [KEY_W-1:0]   rd_key;
  logic               hit;
  logic               scan_end;
  logic               out_free;

  krt_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign rd_key   = rd_data[KEY_LSB +: KEY_W];
  assign hit      = chk_v_r && (rd_key == key_r);
  assign scan_end = (idx_r >= count_r);
  assign out_free = !out_valid_r || !out_stall;

  assign sts.op         = op_r;
  assign sts.full       = (count_r == IW'(TABLE_DEPTH));
  assign sts.hit        = hit;
  assign sts.scan_end   = scan_end;
  assign sts.shift_done = scan_end && !chk_v_r;
  assign sts.out_free   = out_free;

  always_comb begin
    op_nxt         = op_r;
    key_nxt        = key_r;
    price_nxt      = price_r;
    qty_nxt        = qty_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    chk_nxt        = chk_r;
    chk_v_nxt      = chk_v_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_price_nxt  = res_price_r;
    res_qty_nxt    = res_qty_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_price_nxt  = out_price_r;
    out_qty_nxt    = out_qty_r;
    out_cnt_nxt    = out_cnt_r;
    we             = 1'b0;
    waddr          = count_r[AW-1:0];
    wdata          = {key_r, price_r, qty_r};
    raddr          = idx_r[AW-1:0];

    if (cmd.load) begin
      op_nxt         = op_t'(in_operation);
      key_nxt        = in_item_key;
      price_nxt      = in_item_price;
      qty_nxt        = in_item_quantity;
      idx_nxt        = '0;
      chk_v_nxt      = 1'b0;
      res_status_nxt = ST_OK;
      res_key_nxt    = '0;
      res_price_nxt  = '0;
      res_qty_nxt    = '0;
    end

    if (cmd.add) begin
      we        = 1'b1;
      count_nxt = count_r + IW'(1);
    end

    if (cmd.set_status) begin
      res_status_nxt = cmd.status;
    end

    // Search: issue one read a beat, compare the word read the beat before
    if (cmd.scan) begin
      if (hit) begin
        res_key_nxt = rd_key;
        if (op_r == OP_FIND) begin
          res_price_nxt = rd_data[PRICE_LSB +: PRICE_W];
          res_qty_nxt   = rd_data[QTY_LSB +: QTY_W];
        end
        if (op_r == OP_UPDATE) begin
          we    = 1'b1;
          waddr = chk_r;
        end
        // Removal copies down starting from the entry after the match
        idx_nxt   = IW'(chk_r) + IW'(1);
        chk_v_nxt = 1'b0;
      end else if (!scan_end) begin
        idx_nxt   = idx_r + IW'(1);
        chk_nxt   = idx_r[AW-1:0];
        chk_v_nxt = 1'b1;
      end
    end

    // Compaction: read entry j+1, write it to entry j a beat later
    if (cmd.shift) begin
      chk_v_nxt = 1'b0;
      if (chk_v_r) begin
        we    = 1'b1;
        waddr = chk_r - AW'(1);
        wdata = rd_data;
      end
      if (!scan_end) begin
        idx_nxt   = idx_r + IW'(1);
        chk_nxt   = idx_r[AW-1:0];
        chk_v_nxt = 1'b1;
      end else if (!chk_v_r) begin
        count_nxt = count_r - IW'(1);
      end
    end

    if (cmd.finish && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_key_nxt    = res_key_r;
      out_price_nxt  = res_price_r;
      out_qty_nxt    = res_qty_r;
      out_cnt_nxt    = CNT_W'(count_r);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    price_r      <= price_nxt;
    qty_r        <= qty_nxt;
    chk_r        <= chk_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_price_r  <= res_price_nxt;
    res_qty_r    <= res_qty_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_price_r  <= out_price_nxt;
    out_qty_r    <= out_qty_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_key      = out_key_r;
  assign out_found_price    = out_price_r;
  assign out_found_quantity = out_qty_r;
  assign out_entry_count    = out_cnt_r;

endmodule

`default_nettype wire
